>>> sv/txrba_pkg.sv
// Shared types and constants for the transmit ring buffer allocator.
package txrba_pkg;

    // Default size of the circular word store
    localparam int DEF_STORE_WORDS = 4096;
    // Descriptor ring depth and index width
    localparam int RING_ENTRIES = 16;
    localparam int IDX_W = $clog2(RING_ENTRIES);
    // Pending counter width, holds RING_ENTRIES itself
    localparam int PEND_W = $clog2(RING_ENTRIES + 1);
    // Highest pending count at which an allocate may still proceed
    localparam logic [PEND_W-1:0] MAX_PENDING_OK = PEND_W'(13);

    // Field widths of one transaction
    localparam int LEN_W = 16;
    localparam int WORDS_W = LEN_W - 1;
    localparam int OFFSET_W = 13;

    // Request codes
    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_EMPTY    = 2'd2
    } status_t;

    // Ring update commands from the decision logic
    typedef struct packed {
        logic alloc_ok;
        logic wrap;
        logic release_ok;
    } ring_update_t;

endpackage

>>> sv/txrba_ctrl.sv
// Allocate and release decision logic for one request.
module txrba_ctrl #(
    parameter int STORE_WORDS = txrba_pkg::DEF_STORE_WORDS,
    parameter int SW = $clog2(STORE_WORDS + 1)
) (
    input  logic                        valid,
    input  logic                        req_type,
    input  logic [txrba_pkg::LEN_W-1:0] byte_length,
    input  logic [txrba_pkg::PEND_W-1:0] pending,
    input  logic [SW-1:0]               head_start,
    input  logic [SW-1:0]               tail_start,
    output txrba_pkg::ring_update_t     upd,
    output logic [SW-1:0]               place,
    output logic [SW-1:0]               next_start,
    output txrba_pkg::status_t          status,
    output logic [SW-1:0]               offset
);
    import txrba_pkg::*;

    // Compare width covers both the word count and store offsets
    localparam int CW = ((SW > WORDS_W) ? SW : WORDS_W) + 1;
    localparam logic [CW-1:0] STORE_CW = CW'(STORE_WORDS);

    logic [LEN_W:0]   len_round;
    logic [CW-1:0]    words;
    logic [CW-1:0]    p_cw;
    logic [CW-1:0]    h_cw;
    logic [CW-1:0]    h2_cw;
    logic             pend_ok;
    logic             empty;
    logic             below;
    logic             blocked;
    logic             fit1;
    logic             wrap;
    logic             fit2;
    logic             alloc_ok;
    logic             is_alloc;
    logic [CW-1:0]    end_cw;

    // Round the byte length up to whole words
    assign len_round = {1'b0, byte_length} + (LEN_W + 1)'(3);
    assign words     = CW'(len_round[LEN_W:2]);

    assign p_cw    = CW'(tail_start);
    assign h_cw    = CW'(head_start);
    assign empty   = (pending == '0);
    assign pend_ok = (pending <= MAX_PENDING_OK);
    assign is_alloc = (req_type == REQ_ALLOC);

    // First placement check at the tail start
    assign below   = (p_cw < h_cw);
    assign blocked = (p_cw == h_cw) && !empty;
    assign fit1    = below ? (words <= (h_cw - p_cw)) :
                     (!blocked && (words <= (STORE_CW - p_cw)));
    assign wrap    = !below && !blocked && (words > (STORE_CW - p_cw));

    // Retry at word 0; an empty ring moves its head start along with the tail
    assign h2_cw = empty ? '0 : h_cw;
    assign fit2  = (h2_cw == '0) ? (empty && (words <= STORE_CW)) : (words <= h2_cw);

    assign alloc_ok = pend_ok && (fit1 || (wrap && fit2));
    assign place    = wrap ? '0 : tail_start;
    assign end_cw   = CW'(place) + words;
    assign next_start = end_cw[SW-1:0];

    // Gate the updates by the accepted transaction
    always_comb
    begin
        upd.alloc_ok   = valid && is_alloc && alloc_ok;
        upd.wrap       = valid && is_alloc && pend_ok && wrap;
        upd.release_ok = valid && !is_alloc && !empty;
    end

    // Build the result fields
    always_comb
    begin
        if (is_alloc)
        begin
            status = alloc_ok ? STATUS_OK : STATUS_NO_SPACE;
            offset = alloc_ok ? place : '0;
        end
        else
        begin
            status = empty ? STATUS_EMPTY : STATUS_OK;
            offset = empty ? '0 : head_start;
        end
    end

endmodule

>>> sv/txrba_ring.sv
// Descriptor ring: start and length entries, indices, pending count, cached head and tail fields.
module txrba_ring #(
    parameter int STORE_WORDS = txrba_pkg::DEF_STORE_WORDS,
    parameter int SW = $clog2(STORE_WORDS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  txrba_pkg::ring_update_t      upd,
    input  logic [txrba_pkg::LEN_W-1:0]  byte_length,
    input  logic [SW-1:0]                place,
    input  logic [SW-1:0]                next_start,
    output logic [txrba_pkg::PEND_W-1:0] pending,
    output logic [SW-1:0]                head_start,
    output logic [SW-1:0]                tail_start,
    output logic [txrba_pkg::LEN_W-1:0]  head_length
);
    import txrba_pkg::*;

    logic [SW-1:0]     start_mem_reg [RING_ENTRIES];
    logic [LEN_W-1:0]  len_mem_reg [RING_ENTRIES];
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  head_plus;
    logic [IDX_W-1:0]  tail_plus;
    logic [PEND_W-1:0] pending_reg;
    logic [SW-1:0]     head_start_reg;
    logic [SW-1:0]     tail_start_reg;
    logic [LEN_W-1:0]  head_len_reg;

    assign head_plus = head_reg + IDX_W'(1);
    assign tail_plus = tail_reg + IDX_W'(1);

    // Record descriptors; entries are read only after they are written
    always_ff @(posedge clk)
    begin
        if (upd.alloc_ok)
        begin
            start_mem_reg[tail_reg]  <= place;
            start_mem_reg[tail_plus] <= next_start;
            len_mem_reg[tail_reg]    <= byte_length;
        end
        else if (upd.wrap)
        begin
            start_mem_reg[tail_reg] <= '0;
        end
    end

    // Advance indices, pending count and the cached head and tail fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            pending_reg    <= '0;
            head_start_reg <= '0;
            tail_start_reg <= '0;
            head_len_reg   <= '0;
        end
        else
        begin
            if (upd.alloc_ok)
            begin
                tail_reg       <= tail_plus;
                pending_reg    <= pending_reg + PEND_W'(1);
                tail_start_reg <= next_start;
                // An empty ring fills its head entry
                if (pending_reg == '0)
                begin
                    head_len_reg <= byte_length;
                end
            end
            else if (upd.wrap)
            begin
                tail_start_reg <= '0;
            end

            // Head and tail share an entry while nothing is pending
            if (upd.wrap && (pending_reg == '0))
            begin
                head_start_reg <= '0;
            end

            if (upd.release_ok)
            begin
                head_reg    <= head_plus;
                pending_reg <= pending_reg - PEND_W'(1);
                if (pending_reg == PEND_W'(1))
                begin
                    head_start_reg <= tail_start_reg;
                    head_len_reg   <= '0;
                end
                else
                begin
                    head_start_reg <= start_mem_reg[head_plus];
                    head_len_reg   <= len_mem_reg[head_plus];
                end
            end
        end
    end

    assign pending     = pending_reg;
    assign head_start  = head_start_reg;
    assign tail_start  = tail_start_reg;
    assign head_length = head_len_reg;

endmodule

>>> sv/tx_ring_buffer_allocator.sv
// Top level of the transmit ring buffer allocator with the result register.
//
// Usage: drive req_type and byte_length and raise start for one cycle per
// transaction; a transaction is taken at a rising edge with start high and
// busy low. busy stays low, so a new request can be issued every cycle.
// req_type 0 allocates room for byte_length bytes (rounded up to words) in
// the circular word store; req_type 1 releases the oldest pending packet.
// Each transaction gives one result in the next cycle: done is high for
// exactly one cycle with status, word_offset, packet_bytes and
// pending_count valid in that cycle. Throughput is one transaction per
// cycle; the decision path is a few compares on the cached head and
// tail start offsets between the ring registers and the result register.
// The receiver cannot stall: a result is presented once and is taken in
// that cycle. Reset empties the ring (head, tail and pending at zero,
// both starts at word 0) and clears done.
module tx_ring_buffer_allocator #(
    parameter int STORE_WORDS = txrba_pkg::DEF_STORE_WORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            req_type,
    input  logic [txrba_pkg::LEN_W-1:0]     byte_length,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [txrba_pkg::OFFSET_W-1:0]  word_offset,
    output logic [txrba_pkg::LEN_W-1:0]     packet_bytes,
    output logic [txrba_pkg::PEND_W-1:0]    pending_count
);
    import txrba_pkg::*;

    localparam int SW = $clog2(STORE_WORDS + 1);

    logic              accept;
    ring_update_t      upd;
    logic [SW-1:0]     place;
    logic [SW-1:0]     next_start;
    logic [PEND_W-1:0] pending;
    logic [SW-1:0]     head_start;
    logic [SW-1:0]     tail_start;
    logic [LEN_W-1:0]  head_length;
    status_t           res_status;
    logic [SW-1:0]     res_offset;
    logic [31:0]       offset_wide;
    logic [PEND_W-1:0] pending_after;

    logic                done_reg;
    status_t             status_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [LEN_W-1:0]    bytes_reg;
    logic [PEND_W-1:0]   pending_out_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    txrba_ctrl #(
        .STORE_WORDS (STORE_WORDS),
        .SW          (SW)
    ) u_ctrl (
        .valid       (accept),
        .req_type    (req_type),
        .byte_length (byte_length),
        .pending     (pending),
        .head_start  (head_start),
        .tail_start  (tail_start),
        .upd         (upd),
        .place       (place),
        .next_start  (next_start),
        .status      (res_status),
        .offset      (res_offset)
    );

    txrba_ring #(
        .STORE_WORDS (STORE_WORDS),
        .SW          (SW)
    ) u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (upd),
        .byte_length (byte_length),
        .place       (place),
        .next_start  (next_start),
        .pending     (pending),
        .head_start  (head_start),
        .tail_start  (tail_start),
        .head_length (head_length)
    );

    // Fit the offset to the result field width
    assign offset_wide = 32'(res_offset);

    // Pending count after this transaction
    always_comb
    begin
        pending_after = pending;
        if (upd.alloc_ok)
        begin
            pending_after = pending + PEND_W'(1);
        end
        else if (upd.release_ok)
        begin
            pending_after = pending - PEND_W'(1);
        end
    end

    // Strobe for one cycle per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    // Hold the result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= res_status;
            offset_reg      <= offset_wide[OFFSET_W-1:0];
            bytes_reg       <= upd.release_ok ? head_length : '0;
            pending_out_reg <= pending_after;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign word_offset   = offset_reg;
    assign packet_bytes  = bytes_reg;
    assign pending_count = pending_out_reg;

endmodule
